[rtl/mrtt_pkg.sv]
`timescale 1ns / 1ps

package mrtt_pkg;

  // field widths
  localparam int TS_W     = 48;
  localparam int IVL_W    = 20;
  localparam int TEMPO_W  = 18;
  localparam int SPOS_W   = 15;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // midi status bytes
  localparam logic [7:0] STATUS_CLOCK    = 8'hF8;
  localparam logic [7:0] STATUS_START    = 8'hFA;
  localparam logic [7:0] STATUS_CONTINUE = 8'hFB;
  localparam logic [7:0] STATUS_STOP     = 8'hFC;
  localparam logic [7:0] STATUS_SONG_POS = 8'hF2;

  // message lengths
  localparam logic [1:0] LEN_ONE   = 2'd1;
  localparam logic [1:0] LEN_THREE = 2'd3;

  // item commands
  localparam logic CMD_PROCESS     = 1'b0;
  localparam logic CMD_RESET_TEMPO = 1'b1;

  // tempo scaling: twice 60e6 us/min * 100 / 24 pulses, for round-half-up
  localparam longint unsigned TEMPO_SCALE2 = 64'd500000000;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX = 18'd250000;

  // register map
  localparam logic [1:0] REG_TRANSPORT = 2'd0;
  localparam logic [1:0] REG_MIN_IVL   = 2'd1;
  localparam logic [1:0] REG_MAX_IVL   = 2'd2;

  localparam logic [IVL_W-1:0] MIN_IVL_RESET = 20'd1000;
  localparam logic [IVL_W-1:0] MAX_IVL_RESET = 20'd1000000;

  typedef enum logic [1:0] {
    KIND_TEMPO     = 2'd0,
    KIND_TRANSPORT = 2'd1,
    KIND_SONG_POS  = 2'd2,
    KIND_CHANNEL   = 2'd3
  } kind_t;

  typedef struct packed {
    logic             transport_enable;
    logic [IVL_W-1:0] min_interval_us;
    logic [IVL_W-1:0] max_interval_us;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic latch;
    logic eval;
    logic ring_upd;
    logic prep;
    logic div_step;
    logic finish;
    logic load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic reset_cmd;
    logic clock_msg;
    logic has_result;
    logic in_range;
    logic sum_zero;
    logic div_done;
  } dp_status_t;

endpackage

[rtl/mrtt_if.sv]
`timescale 1ns / 1ps

// input message channel
interface mrtt_item_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [7:0]                  status_byte;
  logic [7:0]                  data_first;
  logic [7:0]                  data_second;
  logic [1:0]                  msg_length;
  logic [1:0]                  device;
  logic [mrtt_pkg::TS_W-1:0]   timestamp_us;

  modport source (
    output valid, command, status_byte, data_first, data_second, msg_length, device,
           timestamp_us,
    input  ready
  );
  modport sink (
    input  valid, command, status_byte, data_first, data_second, msg_length, device,
           timestamp_us,
    output ready
  );
endinterface

// result channel
interface mrtt_result_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic [mrtt_pkg::TEMPO_W-1:0]   tempo_centibpm;
  logic [7:0]                     status_out;
  logic [7:0]                     data_first_out;
  logic [7:0]                     data_second_out;
  logic [1:0]                     device_out;
  logic [mrtt_pkg::SPOS_W-1:0]    song_position;

  modport source (
    output valid, kind, tempo_centibpm, status_out, data_first_out, data_second_out,
           device_out, song_position,
    input  ready
  );
  modport sink (
    input  valid, kind, tempo_centibpm, status_out, data_first_out, data_second_out,
           device_out, song_position,
    output ready
  );
endinterface

[rtl/mrtt_regs.sv]
`timescale 1ns / 1ps

module mrtt_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrtt_pkg::ADDR_W-1:0] paddr,
  input  logic [mrtt_pkg::DATA_W-1:0] pwdata,
  output logic [mrtt_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output mrtt_pkg::cfg_t              cfg
);
  import mrtt_pkg::*;

  logic [1:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.transport_enable <= 1'b0;
      cfg.min_interval_us  <= MIN_IVL_RESET;
      cfg.max_interval_us  <= MAX_IVL_RESET;
    end else if (wr_en) begin
      case (reg_index)
        REG_TRANSPORT: cfg.transport_enable <= pwdata[0];
        REG_MIN_IVL:   cfg.min_interval_us  <= pwdata[IVL_W-1:0];
        REG_MAX_IVL:   cfg.max_interval_us  <= pwdata[IVL_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_index)
      REG_TRANSPORT: prdata = {{(DATA_W-1){1'b0}}, cfg.transport_enable};
      REG_MIN_IVL:   prdata = {{(DATA_W-IVL_W){1'b0}}, cfg.min_interval_us};
      REG_MAX_IVL:   prdata = {{(DATA_W-IVL_W){1'b0}}, cfg.max_interval_us};
      default:       prdata = '0;
    endcase
  end

endmodule

[rtl/mrtt_ctrl.sv]
`timescale 1ns / 1ps

module mrtt_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  mrtt_pkg::dp_status_t   status,
  output mrtt_pkg::ctrl_cmd_t    cmd
);
  import mrtt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_RING,
    S_PREP,
    S_DIV,
    S_FIN,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // next state and datapath commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.reset_cmd) begin
          state_next = S_IDLE;
        end else if (status.clock_msg && status.in_range) begin
          state_next = S_RING;
        end else if (status.has_result) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_RING: begin
        cmd.ring_upd = 1'b1;
        state_next   = S_PREP;
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.sum_zero ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/mrtt_datapath.sv]
`timescale 1ns / 1ps

module mrtt_datapath #(
  parameter int RING_DEPTH = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mrtt_pkg::ctrl_cmd_t          cmd,
  output mrtt_pkg::dp_status_t         status,
  input  mrtt_pkg::cfg_t               cfg,
  input  logic                         command,
  input  logic [7:0]                   status_byte,
  input  logic [7:0]                   data_first,
  input  logic [7:0]                   data_second,
  input  logic [1:0]                   msg_length,
  input  logic [1:0]                   device,
  input  logic [mrtt_pkg::TS_W-1:0]    timestamp_us,
  output logic [1:0]                   kind,
  output logic [mrtt_pkg::TEMPO_W-1:0] tempo_centibpm,
  output logic [7:0]                   status_out,
  output logic [7:0]                   data_first_out,
  output logic [7:0]                   data_second_out,
  output logic [1:0]                   device_out,
  output logic [mrtt_pkg::SPOS_W-1:0]  song_position
);
  import mrtt_pkg::*;

  localparam int IDX_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int SUM_W  = IVL_W + $clog2(RING_DEPTH);
  localparam int DVS_W  = SUM_W + 1;
  localparam longint unsigned NUM_MAX = TEMPO_SCALE2 * longint'(RING_DEPTH)
                                      + ((longint'(1) << IVL_W) - 1) * longint'(RING_DEPTH);
  localparam int NUM_W  = $clog2(NUM_MAX + 1);
  localparam int STEP_W = $clog2(NUM_W + 1);

  // latched item
  logic              cmd_q;
  logic [7:0]        st_q;
  logic [7:0]        d1_q;
  logic [7:0]        d2_q;
  logic [1:0]        len_q;
  logic [1:0]        dev_q;
  logic [TS_W-1:0]   ts_q;

  // tempo state
  logic [TS_W-1:0]    last_pulse_time;
  logic               pulse_seen;
  logic [IVL_W-1:0]   interval_ring [RING_DEPTH];
  logic [IVL_W-1:0]   ring_rd;
  logic [IDX_W-1:0]   ring_write_index;
  logic               ring_full;
  logic [SUM_W-1:0]   interval_sum;
  logic [TEMPO_W-1:0] tempo_value;
  logic [IVL_W-1:0]   ivl;

  // divider
  logic [NUM_W-1:0]   quo;
  logic [DVS_W-1:0]   rem;
  logic [DVS_W-1:0]   dvs;
  logic [STEP_W-1:0]  steps;

  logic               is_clock;
  logic               is_transport;
  logic [TS_W-1:0]    ivl_full;
  logic [CNT_W-1:0]   count;
  logic [DVS_W:0]     rem_sh;
  logic               q_bit;

  // message classification
  always_comb begin
    is_clock     = (len_q == LEN_ONE) && (st_q == STATUS_CLOCK);
    is_transport = (len_q == LEN_ONE) &&
                   (st_q inside {STATUS_START, STATUS_CONTINUE, STATUS_STOP});
  end

  assign ivl_full = ts_q - last_pulse_time;
  assign count    = ring_full ? CNT_W'(RING_DEPTH) : CNT_W'(ring_write_index);
  assign rem_sh   = {rem, quo[NUM_W-1]};
  assign q_bit    = (rem_sh >= {1'b0, dvs});

  assign status.reset_cmd  = (cmd_q == CMD_RESET_TEMPO);
  assign status.clock_msg  = is_clock;
  assign status.has_result = (cmd_q == CMD_PROCESS) &&
                             (is_clock || (is_transport && cfg.transport_enable) ||
                              (len_q == LEN_THREE));
  assign status.in_range   = pulse_seen &&
                             (ivl_full > TS_W'(cfg.min_interval_us)) &&
                             (ivl_full < TS_W'(cfg.max_interval_us));
  assign status.sum_zero   = (interval_sum == '0);
  assign status.div_done   = (steps == '0);

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_q <= command;
      st_q  <= status_byte;
      d1_q  <= data_first;
      d2_q  <= data_second;
      len_q <= msg_length;
      dev_q <= device;
      ts_q  <= timestamp_us;
    end
  end

  // interval ring, registered read at the write index
  always_ff @(posedge clk) begin
    if (cmd.ring_upd) begin
      interval_ring[ring_write_index] <= ivl;
    end
    ring_rd <= interval_ring[ring_write_index];
  end

  // pulse timing, ring bookkeeping and tempo
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pulse_time  <= '0;
      pulse_seen       <= 1'b0;
      ring_write_index <= '0;
      ring_full        <= 1'b0;
      interval_sum     <= '0;
      tempo_value      <= '0;
    end else if (cmd.eval && (cmd_q == CMD_RESET_TEMPO)) begin
      last_pulse_time  <= '0;
      pulse_seen       <= 1'b0;
      ring_write_index <= '0;
      ring_full        <= 1'b0;
      interval_sum     <= '0;
      tempo_value      <= '0;
    end else begin
      if (cmd.eval && is_clock) begin
        last_pulse_time <= ts_q;
        pulse_seen      <= 1'b1;
      end
      if (cmd.ring_upd) begin
        interval_sum <= interval_sum - (ring_full ? SUM_W'(ring_rd) : '0) + SUM_W'(ivl);
        if (ring_write_index == IDX_W'(RING_DEPTH - 1)) begin
          ring_write_index <= '0;
          ring_full        <= 1'b1;
        end else begin
          ring_write_index <= ring_write_index + 1'b1;
        end
      end
      if (cmd.finish) begin
        tempo_value <= (quo > NUM_W'(TEMPO_MAX)) ? TEMPO_MAX : quo[TEMPO_W-1:0];
      end
    end
  end

  // measured interval, fits since it lies below the 20-bit maximum
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      ivl <= ivl_full[IVL_W-1:0];
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (cmd.prep) begin
      steps <= STEP_W'(NUM_W);
    end else if (cmd.div_step) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      quo <= NUM_W'(TEMPO_SCALE2) * NUM_W'(count) + NUM_W'(interval_sum);
      dvs <= {interval_sum, 1'b0};
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[NUM_W-2:0], q_bit};
      rem <= q_bit ? DVS_W'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_W-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      tempo_centibpm  <= '0;
      status_out      <= '0;
      data_first_out  <= '0;
      data_second_out <= '0;
      device_out      <= '0;
      song_position   <= '0;
      if (is_clock) begin
        kind           <= KIND_TEMPO;
        tempo_centibpm <= tempo_value;
      end else if (is_transport) begin
        kind       <= KIND_TRANSPORT;
        status_out <= st_q;
      end else if (st_q == STATUS_SONG_POS) begin
        kind          <= KIND_SONG_POS;
        song_position <= SPOS_W'(d1_q) | {d2_q, 7'b0};
      end else begin
        kind            <= KIND_CHANNEL;
        status_out      <= st_q;
        data_first_out  <= d1_q;
        data_second_out <= d2_q;
        device_out      <= dev_q;
      end
    end
  end

endmodule

[rtl/midi_realtime_tempo_tracker.sv]
`timescale 1ns / 1ps

// midi clock tempo tracker, 24 pulses per quarter note
// in_ch carries one time-stamped midi message per beat; out_ch carries at most
// one result per message: a tempo report for every clock byte, a transport
// event (when enabled), a song position, or a forwarded three-byte message.
// an item with command set clears the tempo measurement and gives no result.
// the apb port holds transport_enable, min_interval_us and max_interval_us
// at byte addresses 0, 4 and 8; a write lands in the access cycle.
// most messages pass the eval and emit states from acceptance to a result;
// a clock pulse whose interval enters the ring also passes the ring, prep,
// divide and finish states, and the divide state lasts as long as the
// restoring divider takes at one quotient bit per cycle (34-bit dividend at
// RING_DEPTH 24). a dropped message frees the input after the eval state.
// one item is in flight at a time.
// the result sits in an output register; while the receiver stalls, a new
// item can still be accepted and worked on, and it waits only when its own
// result is ready to be loaded.
// reset clears the tempo state and the registers to their defaults; the
// interval ring needs no clearing since an entry is read only after it is
// written.
module midi_realtime_tempo_tracker #(
  parameter int RING_DEPTH = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  mrtt_item_if.sink                   in_ch,
  mrtt_result_if.source               out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mrtt_pkg::ADDR_W-1:0] paddr,
  input  logic [mrtt_pkg::DATA_W-1:0] pwdata,
  output logic [mrtt_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import mrtt_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_accept;

  assign in_accept = in_ch.valid && in_ch.ready;

  // configuration registers
  mrtt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer
  mrtt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // tempo datapath and result register
  mrtt_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg             (cfg),
    .command         (in_ch.command),
    .status_byte     (in_ch.status_byte),
    .data_first      (in_ch.data_first),
    .data_second     (in_ch.data_second),
    .msg_length      (in_ch.msg_length),
    .device          (in_ch.device),
    .timestamp_us    (in_ch.timestamp_us),
    .kind            (out_ch.kind),
    .tempo_centibpm  (out_ch.tempo_centibpm),
    .status_out      (out_ch.status_out),
    .data_first_out  (out_ch.data_first_out),
    .data_second_out (out_ch.data_second_out),
    .device_out      (out_ch.device_out),
    .song_position   (out_ch.song_position)
  );

  // an accepted beat is evaluated in the next cycle
  a_accept_then_eval: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> cmd.eval)
    else $error("accepted item not evaluated");

  // the result register is never overwritten while a result waits
  a_load_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten while stalled");

  // intake and result loading never overlap
  a_no_accept_on_load: assert property (@(posedge clk) disable iff (rst)
    !(in_accept && cmd.load_out))
    else $error("item accepted while a result is loaded");

  // reported tempo stays within its saturation limit
  a_tempo_limit: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.tempo_centibpm <= TEMPO_MAX))
    else $error("tempo above limit");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import mrtt_pkg::*;

  localparam int RING          = 24;
  localparam int SETTLE        = 50;
  localparam int HOLD_LEN      = 300;
  localparam int LIMIT         = 600000;
  localparam int DIR_ROWS      = 25;
  localparam int TE_ROW        = 22;
  localparam int NUM_PHASES    = 8;
  localparam int ITEMS_PER_PHASE = 141;

  typedef struct packed {
    logic              cmd;
    logic [7:0]        st;
    logic [7:0]        d1;
    logic [7:0]        d2;
    logic [1:0]        len;
    logic [1:0]        dev;
    logic [TS_W-1:0]   ts;
  } msg_t;

  typedef struct packed {
    kind_t             kind;
    logic [TEMPO_W-1:0] tempo;
    logic [7:0]        st;
    logic [7:0]        d1;
    logic [7:0]        d2;
    logic [1:0]        dev;
    logic [SPOS_W-1:0] spos;
  } result_t;

  typedef struct packed {
    msg_t    m;
    logic    typed;
    logic    gives;
    result_t want;
  } dir_row_t;

  typedef struct {
    logic             te;
    logic [IVL_W-1:0] lo;
    logic [IVL_W-1:0] hi;
    int               src_idle;
    int               sink_stall;
    bit               pressure;
  } phase_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  mrtt_item_if   in_if ();
  mrtt_result_if out_if ();

  midi_realtime_tempo_tracker dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // tempo tracking model state
  logic [TS_W-1:0]    pulse_time  = '0;
  bit                 pulse_armed = 1'b0;
  logic [IVL_W-1:0]   ivl_ring [RING];
  int                 ring_wr     = 0;
  bit                 ring_wrapped = 1'b0;
  logic [24:0]        ivl_sum     = '0;
  logic [TEMPO_W-1:0] tempo_now   = '0;

  // register copies
  logic               cfg_te  = 1'b0;
  logic [IVL_W-1:0]   cfg_min = MIN_IVL_RESET;
  logic [IVL_W-1:0]   cfg_max = MAX_IVL_RESET;

  result_t pending_results [$];

  int n_errors   = 0;
  int n_items    = 0;
  int n_checked  = 0;
  int n_tempo    = 0;
  int n_sat      = 0;
  int n_resets   = 0;
  int cycle_count = 0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_starts    = 0;
  int hold_seen      = 0;
  int hold_left      = 0;

  logic [TS_W-1:0] ts_now;
  dir_row_t dir_tab [DIR_ROWS];
  phase_t   phases [NUM_PHASES];

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic flag(input string what, input longint unsigned got,
                      input longint unsigned want);
    $display("MISMATCH %s: got 0x%0h expected 0x%0h (cycle %0d)", what, got, want,
             cycle_count);
    n_errors++;
  endtask

  // tempo tracker prediction: returns 1 when the message yields a result
  function automatic bit track_message(input msg_t m, output result_t r);
    logic [TS_W-1:0] gap;
    longint unsigned cnt, s, q;
    r = '0;
    if (m.cmd == CMD_RESET_TEMPO) begin
      pulse_time   = '0;
      pulse_armed  = 1'b0;
      ring_wr      = 0;
      ring_wrapped = 1'b0;
      ivl_sum      = '0;
      tempo_now    = '0;
      return 1'b0;
    end
    if (m.len == LEN_ONE) begin
      if (m.st == STATUS_CLOCK) begin
        if (pulse_armed) begin
          gap = m.ts - pulse_time;
          if (gap > TS_W'(cfg_min) && gap < TS_W'(cfg_max)) begin
            if (ring_wrapped) ivl_sum = ivl_sum - 25'(ivl_ring[ring_wr]);
            ivl_ring[ring_wr] = gap[IVL_W-1:0];
            ivl_sum = ivl_sum + 25'(gap[IVL_W-1:0]);
            if (ring_wr == RING - 1) begin
              ring_wr = 0;
              ring_wrapped = 1'b1;
            end else begin
              ring_wr++;
            end
            cnt = ring_wrapped ? RING : ring_wr;
            s = 64'(ivl_sum);
            if (s != 0) begin
              q = (TEMPO_SCALE2 * cnt + s) / (2 * s);
              tempo_now = (q > 64'(TEMPO_MAX)) ? TEMPO_MAX : TEMPO_W'(q);
            end
          end
        end
        pulse_time  = m.ts;
        pulse_armed = 1'b1;
        r.kind  = KIND_TEMPO;
        r.tempo = tempo_now;
        return 1'b1;
      end
      if (m.st == STATUS_START || m.st == STATUS_CONTINUE || m.st == STATUS_STOP) begin
        if (!cfg_te) return 1'b0;
        r.kind = KIND_TRANSPORT;
        r.st   = m.st;
        return 1'b1;
      end
      return 1'b0;
    end
    if (m.len == LEN_THREE) begin
      if (m.st == STATUS_SONG_POS) begin
        r.kind = KIND_SONG_POS;
        r.spos = SPOS_W'({8'h00, m.d1} | ({8'h00, m.d2} << 7));
        return 1'b1;
      end
      r.kind = KIND_CHANNEL;
      r.st   = m.st;
      r.d1   = m.d1;
      r.d2   = m.d2;
      r.dev  = m.dev;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // directed row, with a typed expectation where given
  function automatic dir_row_t drow(input logic cmd, input logic [7:0] st,
                                    input logic [7:0] d1, input logic [7:0] d2,
                                    input logic [1:0] len, input logic [1:0] dev,
                                    input logic [TS_W-1:0] ts, input logic typed,
                                    input logic gives, input kind_t kind,
                                    input logic [TEMPO_W-1:0] tempo,
                                    input logic [SPOS_W-1:0] spos);
    dir_row_t row;
    row.m     = '{cmd: cmd, st: st, d1: d1, d2: d2, len: len, dev: dev, ts: ts};
    row.typed = typed;
    row.gives = gives;
    row.want  = '0;
    row.want.kind  = kind;
    row.want.tempo = tempo;
    row.want.spos  = spos;
    if (kind == KIND_TRANSPORT || kind == KIND_CHANNEL) row.want.st = st;
    if (kind == KIND_CHANNEL) begin
      row.want.d1  = d1;
      row.want.d2  = d2;
      row.want.dev = dev;
    end
    return row;
  endfunction

  // offer one message beat and record what it should produce
  task automatic offer(input msg_t m, input logic typed, input logic typed_gives,
                       input result_t typed_want, output bit gives);
    result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid        <= 1'b1;
    in_if.command      <= m.cmd;
    in_if.status_byte  <= m.st;
    in_if.data_first   <= m.d1;
    in_if.data_second  <= m.d2;
    in_if.msg_length   <= m.len;
    in_if.device       <= m.dev;
    in_if.timestamp_us <= m.ts;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    gives = track_message(m, r);
    if (typed) begin
      gives = typed_gives;
      r = typed_want;
    end
    if (gives) pending_results.push_back(r);
    if (m.cmd == CMD_RESET_TEMPO) n_resets++;
    n_items++;
    @(negedge clk);
  endtask

  // wait for all results, then let any dropped item finish
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic check_reg(input logic [1:0] idx, input logic [DATA_W-1:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_W'({idx, 2'b00});
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== want) flag($sformatf("register %0d readback", idx), 64'(prdata), 64'(want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [IVL_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= DATA_W'(value);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_TRANSPORT: cfg_te  = value[0];
      REG_MIN_IVL:   cfg_min = value;
      REG_MAX_IVL:   cfg_max = value;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    check_reg(idx, (idx == REG_TRANSPORT) ? DATA_W'(value[0]) : DATA_W'(value));
  endtask

  // random traffic, mostly clock pulses with intervals around the window
  task automatic run_phase(input int n_want);
    msg_t m;
    bit gives;
    int made, r, r2;
    longint unsigned lo, hi, step;
    made = 0;
    while (made < n_want) begin
      lo = 64'(cfg_min);
      hi = 64'(cfg_max);
      m.cmd = CMD_PROCESS;
      m.st  = STATUS_CLOCK;
      m.len = LEN_ONE;
      m.d1  = 8'($urandom);
      m.d2  = 8'($urandom);
      m.dev = 2'($urandom);
      r = $urandom_range(99);
      if (r < 2) begin
        m.cmd = CMD_RESET_TEMPO;
        m.st  = 8'($urandom);
        m.len = 2'($urandom);
      end else if (r < 62) begin
        r2 = $urandom_range(99);
        if (r2 < 55) begin
          if (hi > lo + 1) step = $urandom_range(32'(hi - 1), 32'(lo + 1));
          else step = $urandom_range(1048575, 0);
        end else if (r2 < 62) step = lo;
        else if (r2 < 69) step = hi;
        else if (r2 < 74) step = lo + 1;
        else if (r2 < 79) step = hi - 1;
        else if (r2 < 92) step = $urandom_range(3000, 0);
        else step = {$urandom, $urandom};
        ts_now = TS_W'(64'(ts_now) + step);
      end else if (r < 72) begin
        case ($urandom_range(2))
          0: m.st = STATUS_START;
          1: m.st = STATUS_CONTINUE;
          default: m.st = STATUS_STOP;
        endcase
        if ($urandom_range(9) == 0) m.len = LEN_THREE;
      end else if (r < 80) begin
        m.st  = STATUS_SONG_POS;
        m.len = LEN_THREE;
      end else if (r < 90) begin
        m.st  = 8'($urandom);
        m.len = LEN_THREE;
      end else begin
        m.st  = 8'($urandom);
        m.len = 2'($urandom);
      end
      if (m.st != STATUS_CLOCK || m.len != LEN_ONE) begin
        ts_now = ts_now + TS_W'($urandom_range(400, 0));
      end
      m.ts = (m.len == LEN_ONE && m.st == STATUS_CLOCK) ? ts_now :
             (($urandom_range(1) == 0) ? ts_now : TS_W'({$urandom, $urandom}));
      offer(m, 1'b0, 1'b0, '0, gives);
      made++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        flag("result with nothing expected, kind", 64'(out_if.kind), 0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_if.kind !== want.kind) flag("kind", 64'(out_if.kind), 64'(want.kind));
        if (out_if.tempo_centibpm !== want.tempo)
          flag("tempo_centibpm", 64'(out_if.tempo_centibpm), 64'(want.tempo));
        if (out_if.status_out !== want.st)
          flag("status_out", 64'(out_if.status_out), 64'(want.st));
        if (out_if.data_first_out !== want.d1)
          flag("data_first_out", 64'(out_if.data_first_out), 64'(want.d1));
        if (out_if.data_second_out !== want.d2)
          flag("data_second_out", 64'(out_if.data_second_out), 64'(want.d2));
        if (out_if.device_out !== want.dev)
          flag("device_out", 64'(out_if.device_out), 64'(want.dev));
        if (out_if.song_position !== want.spos)
          flag("song_position", 64'(out_if.song_position), 64'(want.spos));
        if (want.kind == KIND_TEMPO) begin
          n_tempo++;
          if (want.tempo == TEMPO_MAX) n_sat++;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off in the pressure phase
  initial begin
    out_if.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_starts) begin
        hold_seen = hold_starts;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // main sequence
  initial begin
    bit gives;
    in_if.valid        = 1'b0;
    in_if.command      = CMD_PROCESS;
    in_if.status_byte  = '0;
    in_if.data_first   = '0;
    in_if.data_second  = '0;
    in_if.msg_length   = '0;
    in_if.device       = '0;
    in_if.timestamp_us = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    ts_now  = '0;
    rst     = 1'b1;

    // directed rows under reset settings, transport rows after enabling it
    dir_tab[0]  = drow(0, STATUS_CLOCK, 0, 0, LEN_ONE, 0, 48'd0, 1, 1, KIND_TEMPO, 0, 0);
    dir_tab[1]  = drow(0, STATUS_CLOCK, 0, 0, LEN_ONE, 0, 48'd20833, 0, 0, KIND_TEMPO, 0, 0);
    dir_tab[2]  = drow(0, STATUS_CLOCK, 0, 0, LEN_ONE, 1, 48'd21833, 0, 0, KIND_TEMPO, 0, 0);
    dir_tab[3]  = drow(0, STATUS_CLOCK, 0, 0, LEN_ONE, 2, 48'd1021833, 0, 0, KIND_TEMPO, 0, 0);
    dir_tab[4]  = drow(0, STATUS_CLOCK, 0, 0, LEN_ONE, 3, 48'd1022834, 0, 0, KIND_TEMPO, 0, 0);
    dir_tab[5]  = drow(0, STATUS_START, 0, 0, LEN_ONE, 0, 48'd5, 1, 0, KIND_TEMPO, 0, 0);
    dir_tab[6]  = drow(0, STATUS_CONTINUE, 0, 0, LEN_ONE, 0, 48'd5, 1, 0, KIND_TEMPO, 0, 0);
    dir_tab[7]  = drow(0, STATUS_STOP, 0, 0, LEN_ONE, 0, 48'd5, 1, 0, KIND_TEMPO, 0, 0);
    dir_tab[8]  = drow(0, STATUS_SONG_POS, 8'h7F, 8'h7F, LEN_THREE, 0, 48'd0, 1, 1,
                       KIND_SONG_POS, 0, 15'h3FFF);
    dir_tab[9]  = drow(0, STATUS_SONG_POS, 8'hFF, 8'hFF, LEN_THREE, 1, 48'd0, 1, 1,
                       KIND_SONG_POS, 0, 15'h7FFF);
    dir_tab[10] = drow(0, STATUS_SONG_POS, 8'h00, 8'h00, LEN_THREE, 3, 48'd0, 1, 1,
                       KIND_SONG_POS, 0, 15'h0000);
    dir_tab[11] = drow(0, 8'h90, 8'h3C, 8'h7F, LEN_THREE, 2, 48'd0, 1, 1, KIND_CHANNEL, 0, 0);
    dir_tab[12] = drow(0, STATUS_CLOCK, 8'h00, 8'h00, LEN_THREE, 1, 48'd0, 1, 1,
                       KIND_CHANNEL, 0, 0);
    dir_tab[13] = drow(0, 8'hF0, 8'h7E, 8'h7F, LEN_THREE, 0, 48'd0, 1, 1, KIND_CHANNEL, 0, 0);
    dir_tab[14] = drow(0, STATUS_START, 8'h12, 8'h34, LEN_THREE, 3, 48'd0, 1, 1,
                       KIND_CHANNEL, 0, 0);
    dir_tab[15] = drow(0, 8'hFF, 8'hFF, 8'hFF, LEN_THREE, 3, 48'hFFFF_FFFF_FFFF, 1, 1,
                       KIND_CHANNEL, 0, 0);
    dir_tab[16] = drow(0, 8'h80, 8'h40, 8'h40, 2'd2, 0, 48'd0, 1, 0, KIND_TEMPO, 0, 0);
    dir_tab[17] = drow(0, 8'h00, 8'h00, 8'h00, 2'd0, 0, 48'd0, 1, 0, KIND_TEMPO, 0, 0);
    dir_tab[18] = drow(0, 8'hFE, 8'h00, 8'h00, LEN_ONE, 0, 48'd0, 1, 0, KIND_TEMPO, 0, 0);
    dir_tab[19] = drow(CMD_RESET_TEMPO, STATUS_CLOCK, 8'hAA, 8'h55, LEN_ONE, 2, 48'd77,
                       1, 0, KIND_TEMPO, 0, 0);
    dir_tab[20] = drow(0, STATUS_CLOCK, 0, 0, LEN_ONE, 0, 48'hFFFF_FFFF_FF9C, 1, 1,
                       KIND_TEMPO, 0, 0);
    dir_tab[21] = drow(0, STATUS_CLOCK, 0, 0, LEN_ONE, 0, 48'd20733, 0, 0, KIND_TEMPO, 0, 0);
    dir_tab[22] = drow(0, STATUS_START, 0, 0, LEN_ONE, 1, 48'd0, 1, 1, KIND_TRANSPORT, 0, 0);
    dir_tab[23] = drow(0, STATUS_CONTINUE, 0, 0, LEN_ONE, 2, 48'd0, 1, 1,
                       KIND_TRANSPORT, 0, 0);
    dir_tab[24] = drow(0, STATUS_STOP, 0, 0, LEN_ONE, 3, 48'd0, 1, 1, KIND_TRANSPORT, 0, 0);

    // register settings and idle mix per random phase
    phases[0] = '{1'b0, MIN_IVL_RESET, MAX_IVL_RESET, 0, 0, 1'b0};
    phases[1] = '{1'b1, 20'd0, 20'hFFFFF, 61, 0, 1'b0};
    phases[2] = '{1'b1, 20'd1000, 20'd1000000, 0, 61, 1'b0};
    phases[3] = '{1'b0, 20'hFFFFF, 20'd0, 7, 7, 1'b0};
    phases[4] = '{1'b1, 20'd0, 20'd2000, 0, 0, 1'b1};
    phases[5] = '{1'b1, 20'd5000, 20'd30000, 61, 0, 1'b0};
    phases[6] = '{1'b0, 20'd0, 20'd0, 0, 61, 1'b0};
    phases[7] = '{1'b1, 20'd1000, 20'd1000000, 7, 7, 1'b0};

    // reset
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // register defaults
    check_reg(REG_TRANSPORT, '0);
    check_reg(REG_MIN_IVL, DATA_W'(MIN_IVL_RESET));
    check_reg(REG_MAX_IVL, DATA_W'(MAX_IVL_RESET));

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == TE_ROW) begin
        wait_idle();
        write_reg(REG_TRANSPORT, 20'd1);
      end
      offer(dir_tab[i].m, dir_tab[i].typed, dir_tab[i].gives, dir_tab[i].want, gives);
    end
    wait_idle();

    // random phases
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_TRANSPORT, 20'(phases[p].te));
      write_reg(REG_MIN_IVL, phases[p].lo);
      write_reg(REG_MAX_IVL, phases[p].hi);
      src_idle_pct   = phases[p].src_idle;
      sink_stall_pct = phases[p].sink_stall;
      if (phases[p].pressure) hold_starts++;
      ts_now = TS_W'(48'hFFFF_FFFF_FFFF - TS_W'($urandom_range(50000, 0)));
      run_phase(ITEMS_PER_PHASE);
      wait_idle();
    end

    $display("%0d messages sent, %0d results checked (%0d tempo reports, %0d saturated)",
             n_items, n_checked, n_tempo, n_sat);
    $display("%0d tempo resets, %0d register settings, idle/stall mixes and a long output hold-off",
             n_resets, NUM_PHASES + 1);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
